// ----- rtl/dmc_pkg.sv -----
// Shared constants and types for the direct-mapped cache lookup.
package dmc_pkg;

    localparam int SETS      = 1024;
    localparam int ADDR_BITS = 16;
    localparam int DATA_BITS = 31;
    localparam int CFG_BITS  = 11;
    localparam int IDX_BITS  = $clog2(SETS);
    localparam int DIV_BITS  = $clog2(SETS + 1);
    localparam int CNT_BITS  = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;
    localparam int TAG_W     = ADDR_BITS + DATA_BITS;

    localparam logic [1:0] OUTCOME_HIT     = 2'd0;
    localparam logic [1:0] OUTCOME_FILL    = 2'd1;
    localparam logic [1:0] OUTCOME_REPLACE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CMP
    } t_state;

endpackage

// ----- rtl/direct_mapped_cache_lookup.sv -----
// Direct-mapped cache lookup with a bit-serial set index remainder.
//
// A request is taken at a clock edge where start is high and busy is low; it
// carries the address and the word that backing memory holds there. The set
// is the address modulo sets_in_use (zero counts as one, values above the
// cache size count as the cache size). A hit returns the cached word; a miss
// writes the address and memory word into the entry and returns that word.
// o_outcome tells a hit, a fill of an empty entry and a replacement apart.
//
// Timing: the remainder is formed one address bit per cycle by a restoring
// divider; then a read state reads the entry RAMs and a compare state compares
// and updates. o_done pulses for one cycle after the compare state, and busy
// drops in that same cycle, so the block takes no new item until the last
// one is through. The receiver cannot stall; each result is shown for
// exactly one cycle.
//
// After reset the valid bits are cleared by a pass over all 1024 entries,
// one per cycle, with busy held high. sets_in_use resets to 1024 and may be
// written on any cycle through i_cfg_we / i_cfg_data while the block is idle.
module direct_mapped_cache_lookup (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [dmc_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  logic [dmc_pkg::ADDR_BITS-1:0]   i_addr,
    input  logic [dmc_pkg::DATA_BITS-1:0]   i_mem_data,
    output logic                            o_done,
    output logic [1:0]                      o_outcome,
    output logic [dmc_pkg::IDX_BITS-1:0]    o_set_index,
    output logic [dmc_pkg::DATA_BITS-1:0]   o_read_data
);
    import dmc_pkg::*;

    t_state                r_state, n_state;
    logic [CFG_BITS-1:0]   r_cfg_sets;
    logic [IDX_BITS-1:0]   r_clr_idx, n_clr_idx;
    logic                  r_done, n_done;

    logic [ADDR_BITS-1:0]  r_addr_sh, n_addr_sh;
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic [DATA_BITS-1:0]  r_data, n_data;
    logic [DIV_BITS-1:0]   r_rem, n_rem;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [1:0]            r_outcome, n_outcome;
    logic [IDX_BITS-1:0]   r_set_index, n_set_index;
    logic [DATA_BITS-1:0]  r_read_data, n_read_data;

    logic [DIV_BITS-1:0]   divisor;
    logic [DIV_BITS:0]     partial;
    logic [IDX_BITS-1:0]   idx;

    logic                  v_we, v_wdata, v_rdata;
    logic [IDX_BITS-1:0]   v_waddr;
    logic                  t_we;
    logic [TAG_W-1:0]      t_rdata;
    logic                  hit;

    // Effective divisor: zero acts as one, oversize acts as the cache size.
    always_comb begin
        if (r_cfg_sets == '0) begin
            divisor = DIV_BITS'(1);
        end else if (DIV_BITS'(r_cfg_sets) > DIV_BITS'(SETS)) begin
            divisor = DIV_BITS'(SETS);
        end else begin
            divisor = DIV_BITS'(r_cfg_sets);
        end
    end

    assign partial = {r_rem, r_addr_sh[ADDR_BITS-1]};
    assign idx     = r_rem[IDX_BITS-1:0];
    assign hit     = v_rdata && (t_rdata[TAG_W-1:DATA_BITS] == r_addr);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == IDX_BITS'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_CMP;
            ST_CMP:   n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // Outputs toward the RAMs and the handshake.
    always_comb begin
        busy    = 1'b1;
        v_we    = 1'b0;
        v_waddr = idx;
        v_wdata = 1'b1;
        t_we    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr_idx;
                v_wdata = 1'b0;
            end
            ST_IDLE: busy = 1'b0;
            ST_CMP: begin
                v_we = !hit;
                t_we = !hit;
            end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_clr_idx   = r_clr_idx;
        n_done      = 1'b0;
        n_addr_sh   = r_addr_sh;
        n_addr      = r_addr;
        n_data      = r_data;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_outcome   = r_outcome;
        n_set_index = r_set_index;
        n_read_data = r_read_data;
        unique case (r_state)
            ST_CLEAR: n_clr_idx = r_clr_idx + 1'b1;
            ST_IDLE: begin
                if (start) begin
                    n_addr_sh = i_addr;
                    n_addr    = i_addr;
                    n_data    = i_mem_data;
                    n_rem     = '0;
                    n_cnt     = CNT_BITS'(ADDR_BITS - 1);
                end
            end
            ST_DIV: begin
                // One restoring step: bring in the next address bit, subtract if it fits.
                if (partial >= {1'b0, divisor}) begin
                    n_rem = DIV_BITS'(partial - {1'b0, divisor});
                end else begin
                    n_rem = DIV_BITS'(partial);
                end
                n_addr_sh = r_addr_sh << 1;
                n_cnt     = r_cnt - 1'b1;
            end
            ST_CMP: begin
                n_done      = 1'b1;
                n_set_index = idx;
                if (hit) begin
                    n_outcome   = OUTCOME_HIT;
                    n_read_data = t_rdata[DATA_BITS-1:0];
                end else begin
                    n_outcome   = v_rdata ? OUTCOME_REPLACE : OUTCOME_FILL;
                    n_read_data = r_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_idx  <= '0;
            r_done     <= 1'b0;
            r_cfg_sets <= CFG_BITS'(SETS);
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_done    <= n_done;
            if (i_cfg_we) begin
                r_cfg_sets <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_sh   <= n_addr_sh;
        r_addr      <= n_addr;
        r_data      <= n_data;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_outcome   <= n_outcome;
        r_set_index <= n_set_index;
        r_read_data <= n_read_data;
    end

    dmc_ram #(
        .WIDTH (1),
        .DEPTH (SETS)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (idx),
        .o_rdata (v_rdata)
    );

    dmc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SETS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (idx),
        .i_wdata ({r_addr, r_data}),
        .i_raddr (idx),
        .o_rdata (t_rdata)
    );

    assign o_done      = r_done;
    assign o_outcome   = r_outcome;
    assign o_set_index = r_set_index;
    assign o_read_data = r_read_data;

endmodule

// ----- rtl/dmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dmc_checker.sv -----
// Port-level assertions for the cache lookup and their bind to the top level.
module dmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_outcome
);
    import dmc_pkg::*;

    // A result never shows while an item is still in progress.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after accept");

    // One item gives exactly one strobe cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_outcome == OUTCOME_HIT || o_outcome == OUTCOME_FILL
                    || o_outcome == OUTCOME_REPLACE))
        else $error("undefined outcome code");

endmodule

bind direct_mapped_cache_lookup dmc_checker u_dmc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_done    (o_done),
    .o_outcome (o_outcome)
);
